[rtl/pcpa_pkg.sv]
package pcpa_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CCOUNT_W    = 11;
    localparam int PWR_W       = 3;
    localparam int NUM_COEFFS  = 5;
    localparam int NUM_STEPS   = NUM_COEFFS - 1;
    // highest power still used in the short polynomial
    localparam int LOW_DEGREE  = 2;

    // Horner accumulator: each step adds a data word and a carry bit
    localparam int ACC_W       = DATA_W + NUM_STEPS * (DATA_W + 1);
    localparam int PP_W        = 2 * DATA_W + 1;
    localparam int ROUND_SH    = FRAC_BITS * NUM_STEPS;
    localparam int NSTG        = 2 * NUM_STEPS;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CCOUNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [NUM_COEFFS-1:0][DATA_W-1:0] t_coefs;

    typedef enum logic [1:0] {
        K_WRITE,
        K_EVAL,
        K_COL_ERR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [COL_W-1:0]  column;
        logic [PWR_W-1:0]  power;
        t_word             value;
    } t_item;

    typedef struct packed {
        logic  valid;
        logic  err;
        t_word value;
    } t_lane;

endpackage

[rtl/pcpa_front.sv]
module pcpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [pcpa_pkg::COL_W-1:0]    i_column,
    input  logic [pcpa_pkg::PWR_W-1:0]    i_power_index,
    input  logic signed [pcpa_pkg::DATA_W-1:0] i_value,
    input  logic [pcpa_pkg::CCOUNT_W-1:0] i_column_count,
    input  logic                          i_q_full,
    output logic                          o_push,
    output pcpa_pkg::t_item               o_item
);
    import pcpa_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  keep;
    logic  take;

    always_comb begin
        n_item.column = i_column;
        n_item.power  = i_power_index;
        n_item.value  = i_value;
        n_item.kind   = K_WRITE;
        keep          = 1'b1;
        case (i_action)
            ACT_WRITE: begin
                // drop writes to a power that does not exist
                keep = (i_power_index < PWR_W'(NUM_COEFFS));
            end
            ACT_EVAL: begin
                n_item.kind = (CCOUNT_W'(i_column) >= i_column_count) ? K_COL_ERR : K_EVAL;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = r_valid && i_q_full;
    assign take    = !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/pcpa_queue.sv]
module pcpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcpa_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pcpa_pkg::t_item o_head
);
    import pcpa_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

[rtl/pcpa_coef_store.sv]
module pcpa_coef_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_pop,
    input  pcpa_pkg::t_item  i_item,
    output pcpa_pkg::t_lane  o_lane,
    output pcpa_pkg::t_coefs o_coef
);
    import pcpa_pkg::*;

    logic  wr_en;
    logic  r_valid;
    logic  r_err;
    t_word r_value;

    assign wr_en = i_pop && (i_item.kind == K_WRITE);

    // one bank per power so that an evaluate reads all five at once
    for (genvar b = 0; b < NUM_COEFFS; b++) begin : g_bank
        logic [DATA_W-1:0] r_bank [MAX_COLUMNS];
        logic [DATA_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (wr_en && (i_item.power == PWR_W'(b))) begin
                r_bank[i_item.column] <= i_item.value;
            end
            if (i_adv) begin
                r_q <= r_bank[i_item.column];
            end
        end

        assign o_coef[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_pop && (i_item.kind != K_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_err   <= (i_item.kind == K_COL_ERR);
            r_value <= i_item.value;
        end
    end

    assign o_lane.valid = r_valid;
    assign o_lane.err   = r_err;
    assign o_lane.value = r_value;

endmodule

[rtl/pcpa_horner.sv]
module pcpa_horner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_degree_four,
    input  pcpa_pkg::t_lane                    i_lane,
    input  pcpa_pkg::t_coefs                   i_coef,
    output logic                               o_valid,
    output logic signed [pcpa_pkg::DATA_W-1:0] o_activation,
    output logic                               o_saturated,
    output logic                               o_column_error
);
    import pcpa_pkg::*;

    localparam int Q_W = ACC_W + 1 - ROUND_SH;
    localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1) << (ROUND_SH - 1);

    logic   r_vld [1:NSTG];
    logic   r_err [1:NSTG];
    t_word  r_v   [1:NSTG];
    t_coefs r_c   [1:NSTG];

    logic signed [ACC_W-1:0] r_acc [1:NUM_STEPS];

    t_word acc0;

    logic signed [ACC_W:0]  rnd;
    logic signed [Q_W-1:0]  q;
    logic                   fits;
    t_word                  n_act;
    logic                   n_sat;

    logic  r_out_valid;
    t_word r_act;
    logic  r_sat;
    logic  r_cerr;

    // short polynomial: the top two coefficients count as zero
    assign acc0 = i_degree_four ? $signed(i_coef[NUM_STEPS]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[1] <= i_lane.valid;
            for (int s = 2; s <= NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_err[1] <= i_lane.err;
            r_v[1]   <= i_lane.value;
            r_c[1]   <= i_coef;
            for (int s = 2; s <= NSTG; s++) begin
                r_err[s] <= r_err[s-1];
                r_v[s]   <= r_v[s-1];
                r_c[s]   <= r_c[s-1];
            end
        end
    end

    // step k: acc = acc * v + c[NUM_STEPS-k] << (FRAC_BITS*k), exact width
    for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
        localparam int IN_W  = DATA_W + (k - 1) * (DATA_W + 1);
        localparam int LIMBS = (IN_W + DATA_W - 1) / DATA_W;
        localparam int SH    = FRAC_BITS * k;
        localparam int CI    = NUM_STEPS - k;

        logic signed [ACC_W-1:0]          src;
        t_word                            v_src;
        logic signed [LIMBS*DATA_W-1:0]   a_ext;
        logic signed [PP_W-1:0]           r_pp [LIMBS];
        logic signed [ACC_W-1:0]          term;
        logic signed [ACC_W-1:0]          sum;
        logic                             use_c;

        if (k == 1) begin : g_first
            assign src   = ACC_W'(acc0);
            assign v_src = i_lane.value;
        end else begin : g_rest
            assign src   = r_acc[k-1];
            assign v_src = r_v[2*k-2];
        end

        assign a_ext = src[LIMBS*DATA_W-1:0];

        // split the accumulator into limbs, one product per limb (33x32, the signed top limb 32x32)
        for (genvar j = 0; j < LIMBS; j++) begin : g_limb
            logic signed [PP_W-1:0] pp;
            if (j < LIMBS - 1) begin : g_low
                assign pp = $signed({1'b0, a_ext[j*DATA_W +: DATA_W]}) * v_src;
            end else begin : g_top
                assign pp = $signed(a_ext[j*DATA_W +: DATA_W]) * v_src;
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_pp[j] <= pp;
                end
            end
        end

        assign use_c = i_degree_four || (CI <= LOW_DEGREE);
        assign term  = use_c ? (ACC_W'($signed(r_c[2*k-1][CI])) <<< SH) : '0;

        always_comb begin
            sum = term;
            for (int j = 0; j < LIMBS; j++) begin
                sum = sum + (ACC_W'(r_pp[j]) <<< (j * DATA_W));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_acc[k] <= sum;
            end
        end
    end

    // round half up, then clamp to the word
    always_comb begin
        rnd   = (ACC_W + 1)'(r_acc[NUM_STEPS]) + HALF;
        q     = rnd[ACC_W:ROUND_SH];
        fits  = (&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]);
        n_sat = !fits;
        if (fits) begin
            n_act = q[DATA_W-1:0];
        end else if (q[Q_W-1]) begin
            n_act = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_act = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cerr <= r_err[NSTG];
            r_act  <= r_err[NSTG] ? '0 : n_act;
            r_sat  <= r_err[NSTG] ? 1'b0 : n_sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_activation   = r_act;
    assign o_saturated    = r_sat;
    assign o_column_error = r_cerr;

endmodule

[rtl/per_column_polynomial_activation_core.sv]
// Per-column polynomial activation. Each input item either writes one
// Q16.16 coefficient (column, power 0 to 4) or evaluates
// c0 + c1*v + c2*v^2 (+ c3*v^3 + c4*v^4 when degree_four is set) on a Q16.16
// value for its column, giving one rounded (half up) and saturated Q16.16
// result per evaluate; writes give no result. The block sustains one item per
// clock in either direction while the output is not stalled, set by the
// fully pipelined Horner unit: four multiply/accumulate steps, each a row of
// limb products (33x32, the top limb 32x32) followed by an exact-width add,
// behind single-port coefficient banks (one 1024-word bank per power). An
// accepted item passes classify, queue, bank read, eight Horner stages and
// round and clamp. A 4-entry queue lets input flow while the output is held.
// Coefficients have no reset value: write every coefficient of a column before
// evaluating it. A column at or beyond column_count returns zero with
// column_error set. Configuration is always ready and may only be written
// while the block is idle.
module per_column_polynomial_activation_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pcpa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_action,
    input  logic [pcpa_pkg::COL_W-1:0]            i_column,
    input  logic [pcpa_pkg::PWR_W-1:0]            i_power_index,
    input  logic signed [pcpa_pkg::DATA_W-1:0]    i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pcpa_pkg::DATA_W-1:0]    o_activation,
    output logic                                  o_saturated,
    output logic                                  o_column_error
);
    import pcpa_pkg::*;

    logic                r_degree_four;
    logic [CCOUNT_W-1:0] r_column_count;

    logic   push;
    t_item  front_item;
    logic   q_full;
    logic   q_empty;
    t_item  q_head;
    logic   pop;
    logic   adv;
    t_lane  lane;
    t_coefs coef;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_four  <= 1'b0;
            r_column_count <= CCOUNT_W'(MAX_COLUMNS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEGREE_FOUR:  r_degree_four  <= i_cfg_data[0];
                REG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the whole back end moves together whenever the output register is free
    assign adv = !o_valid || !i_stall;
    assign pop = adv && !q_empty;

    pcpa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_column       (i_column),
        .i_power_index  (i_power_index),
        .i_value        (i_value),
        .i_column_count (r_column_count),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    pcpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pcpa_coef_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_pop   (pop),
        .i_item  (q_head),
        .o_lane  (lane),
        .o_coef  (coef)
    );

    pcpa_horner u_horner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_degree_four  (r_degree_four),
        .i_lane         (lane),
        .i_coef         (coef),
        .o_valid        (o_valid),
        .o_activation   (o_activation),
        .o_saturated    (o_saturated),
        .o_column_error (o_column_error)
    );

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpa_pkg::*;

    localparam int ACC_BITS       = 256;
    localparam int IDLE_PCT       = 27;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE         = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PWR_TOP        = (1 << PWR_W) - 1;
    localparam int NUM_PHASES     = 7;

    localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] activation;
        logic                     saturated;
        logic                     column_error;
    } t_act_result;

    class activation_scoreboard;
        logic [DATA_W-1:0] coef [MAX_COLUMNS][NUM_COEFFS];
        bit                degree_four;
        int unsigned       column_count;
        t_act_result       awaited [$];
        int                errors, writes, evals, col_errors, clamped, checked;

        function new();
            degree_four  = 1'b0;
            column_count = MAX_COLUMNS;
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DEGREE_FOUR) begin
                degree_four = data[0];
            end else begin
                column_count = data;
            end
        endfunction

        // Horner at full width, then round half up and clamp to one word
        function t_act_result evaluate(logic [COL_W-1:0] col, logic signed [DATA_W-1:0] v);
            logic signed [ACC_BITS-1:0] acc, vx, term, half;
            t_act_result r;
            int deg, k;
            deg = degree_four ? NUM_COEFFS - 1 : LOW_DEGREE;
            vx  = v;
            acc = $signed(coef[col][deg]);
            for (k = deg - 1; k >= 0; k--) begin
                term = $signed(coef[col][k]);
                acc  = acc * vx + (term <<< (FRAC_BITS * (deg - k)));
            end
            half = 1;
            acc  = (acc + (half <<< (FRAC_BITS * deg - 1))) >>> (FRAC_BITS * deg);
            r.column_error = 1'b0;
            if (acc[ACC_BITS-1:DATA_W-1] == '0 || &acc[ACC_BITS-1:DATA_W-1]) begin
                r.activation = acc[DATA_W-1:0];
                r.saturated  = 1'b0;
            end else begin
                r.activation = acc[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
                r.saturated  = 1'b1;
            end
            return r;
        endfunction

        function void note_item(logic act, logic [COL_W-1:0] col, logic [PWR_W-1:0] pwr,
                                logic signed [DATA_W-1:0] v);
            t_act_result r;
            if (act == ACT_WRITE) begin
                if (pwr < NUM_COEFFS) begin
                    coef[col][pwr] = v;
                    writes++;
                end
                return;
            end
            evals++;
            if (col >= column_count) begin
                r.activation   = '0;
                r.saturated    = 1'b0;
                r.column_error = 1'b1;
                col_errors++;
            end else begin
                r = evaluate(col, v);
                if (r.saturated) clamped++;
            end
            awaited.push_back(r);
        endfunction

        task check_result(logic signed [DATA_W-1:0] act, logic sat, logic cerr);
            t_act_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result %h arrived with nothing awaited", act));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (act !== want.activation)
                report($sformatf("activation %h, want %h", act, want.activation));
            if (sat !== want.saturated)
                report($sformatf("saturated %b, want %b (activation %h)", sat,
                                 want.saturated, want.activation));
            if (cerr !== want.column_error)
                report($sformatf("column_error %b, want %b", cerr, want.column_error));
        endtask
    endclass

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data     = '0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_action       = ACT_WRITE;
    logic [COL_W-1:0]         i_column       = '0;
    logic [PWR_W-1:0]         i_power_index  = '0;
    logic signed [DATA_W-1:0] i_value        = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic signed [DATA_W-1:0] o_activation;
    logic                     o_saturated;
    logic                     o_column_error;

    activation_scoreboard sb = new();

    bit [NUM_COEFFS-1:0] coef_set [MAX_COLUMNS];
    int                  ready_cols [$];
    int unsigned         active_count = MAX_COLUMNS;
    bit                  calm         = 1'b0;
    bit                  hold_req     = 1'b0;
    int                  idle_cycles  = 0;

    bit ph_deg   [NUM_PHASES] = '{1, 0, 1, 0, 1, 1, 0};
    int ph_count [NUM_PHASES] = '{1024, 1024, 1, 0, 700, -1, 512};
    int ph_items [NUM_PHASES] = '{0, 60, 70, 30, 100, 90, 80};
    bit ph_calm  [NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 0};
    bit ph_hold  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 1};
    int ph_pause [NUM_PHASES] = '{-1, -1, -1, -1, 50, -1, -1};

    per_column_polynomial_activation_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_column       (i_column),
        .i_power_index  (i_power_index),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_activation   (o_activation),
        .o_saturated    (o_saturated),
        .o_column_error (o_column_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] rand_fixed();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return int'($urandom_range(1 << 19)) - (1 << 18);
            5, 6:          return int'($urandom_range(1 << 25)) - (1 << 24);
            7, 8:          return $urandom;
            default: begin
                case ($urandom_range(4))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return 1 << FRAC_BITS;
                endcase
            end
        endcase
    endfunction

    // out-of-range columns read nothing, so any of them may be used
    function automatic int eval_column();
        if (active_count < MAX_COLUMNS && $urandom_range(3) == 0)
            return $urandom_range(MAX_COLUMNS - 1, active_count);
        return ready_cols[$urandom_range(ready_cols.size() - 1)];
    endfunction

    task automatic configure(input bit deg4, input int unsigned count);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_DEGREE_FOUR;
        i_cfg_data  <= CFG_DATA_W'(deg4);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_DEGREE_FOUR, CFG_DATA_W'(deg4));
        i_cfg_index <= REG_COLUMN_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_COLUMN_COUNT, CFG_DATA_W'(count));
        i_cfg_valid  <= 1'b0;
        active_count = count;
    endtask

    task automatic send_item(input logic act, input int col, input int pwr,
                             input logic signed [DATA_W-1:0] v);
        bit was_full;
        i_valid       <= 1'b1;
        i_action      <= act;
        i_column      <= COL_W'(col);
        i_power_index <= PWR_W'(pwr);
        i_value       <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(act, COL_W'(col), PWR_W'(pwr), v);
        if (act == ACT_WRITE && pwr < NUM_COEFFS) begin
            was_full             = &coef_set[col];
            coef_set[col][pwr]   = 1'b1;
            if (!was_full && &coef_set[col]) ready_cols.push_back(col);
        end
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_column(input int col, input logic [DATA_W-1:0] c0, c1, c2, c3, c4);
        send_item(ACT_WRITE, col, 0, c0);
        send_item(ACT_WRITE, col, 1, c1);
        send_item(ACT_WRITE, col, 2, c2);
        send_item(ACT_WRITE, col, 3, c3);
        send_item(ACT_WRITE, col, 4, c4);
    endtask

    task automatic run_directed();
        // c1 of one LSB gives v / 2^16, which lands on exact halves
        load_column(0, '0, 1, '0, '0, '0);
        load_column(MAX_COLUMNS - 1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        load_column(682, 32'h0000_4000, 32'h0000_8000, 32'h0000_2000, 32'hFFFF_F000,
                    32'h0000_0100);
        // powers beyond c4: drop, column 0 must keep its coefficients
        send_item(ACT_WRITE, 0, PWR_TOP, '1);
        send_item(ACT_WRITE, MAX_COLUMNS - 1, NUM_COEFFS, '0);
        send_item(ACT_EVAL, 0, 0, 32'h0000_8000);
        send_item(ACT_EVAL, 0, PWR_TOP, 32'hFFFF_8000);
        send_item(ACT_EVAL, 0, 2, 32'h0001_8000);
        send_item(ACT_EVAL, 0, NUM_COEFFS, 32'hFFFE_8000);
        send_item(ACT_EVAL, MAX_COLUMNS - 1, 1, WORD_MAX);
        send_item(ACT_EVAL, MAX_COLUMNS - 1, 3, WORD_MIN);
        send_item(ACT_EVAL, MAX_COLUMNS - 1, 4, '0);
        send_item(ACT_EVAL, 682, 6, 32'h0001_0000);
    endtask

    task automatic run_random(input int n, input int pause_at);
        int done, col, j, k, tmp, r;
        int order [NUM_COEFFS];
        done = 0;
        while (done < n) begin
            if (pause_at >= 0 && done >= pause_at) begin
                wait_for_results();
                pause_at = -1;
            end
            r = $urandom_range(99);
            if (r < 8) begin
                // bring a random column into use, all powers in shuffled order
                col = $urandom_range(MAX_COLUMNS - 1);
                for (j = 0; j < NUM_COEFFS; j++) order[j] = j;
                for (j = NUM_COEFFS - 1; j > 0; j--) begin
                    k        = $urandom_range(j);
                    tmp      = order[j];
                    order[j] = order[k];
                    order[k] = tmp;
                end
                for (j = 0; j < NUM_COEFFS; j++)
                    send_item(ACT_WRITE, col, order[j], rand_fixed());
                done += NUM_COEFFS;
            end else if (r < 22) begin
                send_item(ACT_WRITE, ready_cols[$urandom_range(ready_cols.size() - 1)],
                          $urandom_range(NUM_COEFFS - 1), rand_fixed());
                done++;
            end else if (r < 26) begin
                send_item(ACT_WRITE, $urandom_range(MAX_COLUMNS - 1),
                          $urandom_range(PWR_TOP, NUM_COEFFS), $urandom);
            end else begin
                send_item(ACT_EVAL, eval_column(), $urandom_range(PWR_TOP), rand_fixed());
                done++;
            end
        end
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result(o_activation, o_saturated, o_column_error);
            if (hold_req && hold_left == 0) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int p;
        int unsigned count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (p = 0; p < NUM_PHASES; p++) begin
            count = (ph_count[p] < 0) ? $urandom_range(MAX_COLUMNS - 1, 2) : ph_count[p];
            configure(ph_deg[p], count);
            calm <= ph_calm[p];
            if (ph_hold[p]) hold_req <= 1'b1;
            if (p == 0) begin
                run_directed();
            end else begin
                run_random(ph_items[p], ph_pause[p]);
            end
            // let writes still in flight retire before the next register change
            wait_for_results();
            repeat (SETTLE) @(posedge i_clk);
        end
        $display("Covered %0d coefficient writes and %0d evaluations in degree 2 and 4,",
                 sb.writes, sb.evals);
        $display("column counts 0 to %0d: %0d column errors, %0d clamped, %0d compared",
                 MAX_COLUMNS, sb.col_errors, sb.clamped, sb.checked);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
